### src/ipv4_longest_prefix_match_unit_defines.svh
// assertion macros for the route lookup unit
`ifndef IPV4_LONGEST_PREFIX_MATCH_UNIT_DEFINES_SVH
`define IPV4_LONGEST_PREFIX_MATCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LPM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define LPM_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define LPM_ASSERT(lbl, clk, rstn, prop)
`define LPM_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

### src/ipv4lpm_pkg.sv
`default_nettype none
package ipv4lpm_pkg;

    localparam int DEF_MAX_ROUTES = 64;
    localparam logic [5:0] MAX_LEN = 6'd32;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_HIT   = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [15:0] out_port;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] port;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic finish_add;
        logic rd_en;
        logic finish_lookup;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic last;
    } t_sts;

    // leading len bits set; zero covers all, 32 and above is exact
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        len_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage
`default_nettype wire

### src/ipv4lpm_ctrl.sv
`default_nettype none
module ipv4lpm_ctrl
    import ipv4lpm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_action,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ADD  = 5'b00010,
        S_SCAN = 5'b00100,
        S_LAST = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_action == ACT_ADD) begin
                        n_state = S_ADD;
                    end else if (i_sts.empty) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_ADD: begin
                o_cmd.finish_add = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.last) begin
                    n_state = S_LAST;
                end
            end
            // last read word is compared here
            S_LAST: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish_lookup = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

### src/ipv4lpm_dp.sv
`default_nettype none
module ipv4lpm_dp
    import ipv4lpm_pkg::*;
#(
    parameter int MAX_ROUTES = DEF_MAX_ROUTES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output logic      o_done,
    output t_rsp      o_rsp
);

    localparam int AW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CW = $clog2(MAX_ROUTES + 1);
    localparam int EW = 32 + 6 + 16;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  len;
        logic [15:0] port;
    } t_entry;

    t_entry      r_mem [MAX_ROUTES];
    t_entry      r_rd;
    t_req        r_req;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_idx;
    logic        r_cmp_v;
    logic        r_found;
    logic [5:0]  r_best_len;
    logic [15:0] r_best_port;
    logic        r_done;
    t_rsp        r_rsp;

    logic        w_full;
    logic        w_match;
    t_entry      w_wr;

    assign w_full = (r_count == CW'(MAX_ROUTES));
    assign w_wr   = t_entry'({r_req.address,
                             (r_req.prefix_len > MAX_LEN) ? MAX_LEN : r_req.prefix_len,
                             r_req.out_port});
    assign w_match = (((r_req.address ^ r_rd.prefix) & len_mask(r_rd.len)) == 32'd0);

    assign o_sts.empty = (r_count == '0);
    assign o_sts.last  = (CW'(r_idx) == r_count - CW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish_add && !w_full) begin
            r_mem[r_count[AW-1:0]] <= w_wr;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_cmp_v <= 1'b0;
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_cmp_v <= i_cmd.rd_en;
            r_done  <= i_cmd.finish_add | i_cmd.finish_lookup;
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.rd_en) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.finish_add && !w_full) begin
                r_count <= r_count + CW'(1);
            end
            // strictly longer wins, so the earliest of equal lengths stays
            if (r_cmp_v && w_match && (!r_found || r_rd.len > r_best_len)) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_v && w_match && (!r_found || r_rd.len > r_best_len)) begin
            r_best_len  <= r_rd.len;
            r_best_port <= r_rd.port;
        end
        if (i_cmd.finish_add) begin
            r_rsp.status <= w_full ? ST_FULL : ST_ADDED;
            r_rsp.port   <= 16'd0;
        end else if (i_cmd.finish_lookup) begin
            r_rsp.status <= r_found ? ST_HIT : ST_MISS;
            r_rsp.port   <= r_found ? r_best_port : 16'd0;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    if (EW != $bits(t_entry)) begin : g_bad_entry
        $error("route entry width mismatch");
    end

endmodule
`default_nettype wire

### src/ipv4_longest_prefix_match_unit.sv
// add request: S_ADD, then a registered result strobe; a new request may start with it
// lookup request: S_SCAN, S_LAST and S_FIN, then the result strobe and a new request
// (only S_FIN with no stored routes); one route is read per cycle from the route memory
// busy is low again when the strobe comes; results cannot be stalled by the receiver
// synchronous active-low reset empties the table; route memory itself is not cleared
`default_nettype none
`include "ipv4_longest_prefix_match_unit_defines.svh"
module ipv4_longest_prefix_match_unit
    import ipv4lpm_pkg::*;
#(
    parameter int MAX_ROUTES = DEF_MAX_ROUTES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_done,
    output t_rsp      o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy;

    ipv4lpm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_req.action),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (w_busy)
    );

    ipv4lpm_dp #(
        .MAX_ROUTES (MAX_ROUTES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    assign busy = w_busy;

    `LPM_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    `LPM_ASSERT(a_done_after_busy, i_clk, i_rst_n, o_done |-> $past(busy))
    `LPM_ASSERT_NEVER(a_port_zero, i_clk, i_rst_n,
        o_done && o_rsp.status != ST_HIT && o_rsp.port != 16'd0)
    `LPM_ASSERT_NEVER(a_cmd_overlap, i_clk, i_rst_n,
        !$onehot0({w_cmd.load, w_cmd.finish_add, w_cmd.rd_en, w_cmd.finish_lookup}))

endmodule
`default_nettype wire
